### design/cdt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Countdown timer and stopwatch package
// Command word passed from the front end to the execution unit, key classes
// and fixed constants shared by the modules of the block.
// ----------------------------------------------------------------------------
package cdt_pkg;

  localparam int ENTRY_DIGITS = 6;

  localparam logic [15:0] TPS_RESET = 16'd31;

  // ASCII key codes
  localparam logic [7:0] KEY_CODE_ZERO   = 8'h30;
  localparam logic [7:0] KEY_CODE_NINE   = 8'h39;
  localparam logic [7:0] KEY_CODE_CLEAR  = 8'h43;
  localparam logic [7:0] KEY_CODE_SLASH  = 8'h2F;
  localparam logic [7:0] KEY_CODE_EQUALS = 8'h3D;
  localparam logic [7:0] KEY_CODE_NOKEY  = 8'h4E;

  // Input action codes
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_TIMER = 2'd1;
  localparam logic [1:0] ACT_WATCH = 2'd2;

  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_TIMER_KEY = 2'd1,
    CMD_WATCH_KEY = 2'd2,
    CMD_IDLE      = 2'd3
  } cmd_kind_t;

  typedef enum logic [2:0] {
    KEY_DIGIT  = 3'd0,
    KEY_CLEAR  = 3'd1,
    KEY_START  = 3'd2,
    KEY_RESET  = 3'd3,
    KEY_NONE   = 3'd4,
    KEY_OTHER  = 3'd5
  } key_class_t;

  typedef struct packed {
    cmd_kind_t  kind;
    key_class_t key;
    logic [3:0] digit;
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);

endpackage

### design/cdt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input classifier
// Turns an incoming word (action and ASCII key) into a compact command for
// the execution unit.
// ----------------------------------------------------------------------------
module cdt_front (
  input  logic [1:0]    action,
  input  logic [7:0]    key_code,
  output cdt_pkg::cmd_t cmd
);

  always_comb begin
    cmd.digit = 4'(key_code - cdt_pkg::KEY_CODE_ZERO);

    unique case (action)
      cdt_pkg::ACT_TICK:  cmd.kind = cdt_pkg::CMD_TICK;
      cdt_pkg::ACT_TIMER: cmd.kind = cdt_pkg::CMD_TIMER_KEY;
      cdt_pkg::ACT_WATCH: cmd.kind = cdt_pkg::CMD_WATCH_KEY;
      default:            cmd.kind = cdt_pkg::CMD_IDLE;
    endcase

    if (key_code >= cdt_pkg::KEY_CODE_ZERO && key_code <= cdt_pkg::KEY_CODE_NINE) begin
      cmd.key = cdt_pkg::KEY_DIGIT;
    end else if (key_code == cdt_pkg::KEY_CODE_CLEAR) begin
      cmd.key = cdt_pkg::KEY_CLEAR;
    end else if (key_code == cdt_pkg::KEY_CODE_SLASH) begin
      cmd.key = cdt_pkg::KEY_START;
    end else if (key_code == cdt_pkg::KEY_CODE_EQUALS) begin
      cmd.key = cdt_pkg::KEY_RESET;
    end else if (key_code == cdt_pkg::KEY_CODE_NOKEY) begin
      cmd.key = cdt_pkg::KEY_NONE;
    end else begin
      cmd.key = cdt_pkg::KEY_OTHER;
    end
  end

endmodule

### design/cdt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command queue
// Small first-in first-out buffer of commands between the classifier and
// the execution unit.
// ----------------------------------------------------------------------------
module cdt_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cdt_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output cdt_pkg::cmd_t head_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  cdt_pkg::cmd_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == FULL_COUNT);
  assign not_empty = (count != '0);
  assign head_cmd  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### design/cdt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Execution unit
// Holds the prescaler, the timer and stopwatch state and the output word
// register. Executes one queued command per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module cdt_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr_en,
  input  logic [15:0]   cfg_wr_data,
  input  logic          cmd_valid,
  input  cdt_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [47:0]   out_data
);

  localparam int ND = cdt_pkg::ENTRY_DIGITS;

  typedef enum logic [1:0] {
    PH_SETTING = 2'd0,
    PH_RUNNING = 2'd1,
    PH_PAUSED  = 2'd2,
    PH_RINGING = 2'd3
  } timer_phase_t;

  typedef enum logic [1:0] {
    W_OFF    = 2'd0,
    W_ON     = 2'd1,
    W_PAUSED = 2'd2
  } watch_phase_t;

  logic [15:0]  tps;
  logic [15:0]  prescale, prescale_next, prescale_inc;
  logic [3:0]   digits [ND];
  logic [3:0]   digits_next [ND];
  timer_phase_t t_phase, t_phase_next;
  watch_phase_t w_phase, w_phase_next;
  // Remaining time is kept already split into hours, minutes and seconds.
  logic [6:0]   t_hrs, t_hrs_next, t_hrs_dec;
  logic [5:0]   t_min, t_min_next, t_min_dec;
  logic [5:0]   t_sec, t_sec_next, t_sec_dec;
  logic [6:0]   w_hrs, w_hrs_next;
  logic [5:0]   w_min, w_min_next;
  logic [5:0]   w_sec, w_sec_next;
  logic         second;

  logic [6:0]   ld_hh, ld_mm, ld_ss, ld_mm_c, ld_hrs;
  logic [5:0]   ld_min, ld_sec;
  logic         ld_s_carry, ld_m_carry, entry_nonzero;
  logic [6:0]   disp_h, disp_m, disp_s;

  function automatic logic [6:0] pair(input logic [3:0] hi, input logic [3:0] lo);
    return {hi, 3'b000} + {2'b00, hi, 1'b0} + {3'b000, lo};
  endfunction

  assign cmd_pop = cmd_valid && (!out_valid || out_ready);

  // Loading the entered digits: each field is at most 99, so a single
  // compare and subtract per field normalises seconds and minutes.
  always_comb begin
    ld_hh = pair(digits[0], digits[1]);
    ld_mm = pair(digits[2], digits[3]);
    ld_ss = pair(digits[4], digits[5]);
    ld_s_carry = (ld_ss >= 7'd60);
    ld_sec  = ld_s_carry ? 6'(ld_ss - 7'd60) : ld_ss[5:0];
    ld_mm_c = ld_mm + {6'd0, ld_s_carry};
    ld_m_carry = (ld_mm_c >= 7'd60);
    ld_min  = ld_m_carry ? 6'(ld_mm_c - 7'd60) : ld_mm_c[5:0];
    ld_hrs  = ld_hh + {6'd0, ld_m_carry};
    entry_nonzero = 1'b0;
    for (int i = 0; i < ND; i++) begin
      entry_nonzero = entry_nonzero | (digits[i] != 4'd0);
    end
  end

  always_comb begin
    t_sec_dec = t_sec;
    t_min_dec = t_min;
    t_hrs_dec = t_hrs;
    if (t_sec != 6'd0) begin
      t_sec_dec = t_sec - 1'b1;
    end else if (t_min != 6'd0) begin
      t_min_dec = t_min - 1'b1;
      t_sec_dec = 6'd59;
    end else if (t_hrs != 7'd0) begin
      t_hrs_dec = t_hrs - 1'b1;
      t_min_dec = 6'd59;
      t_sec_dec = 6'd59;
    end
  end

  always_comb begin
    prescale_next = prescale;
    digits_next   = digits;
    t_phase_next  = t_phase;
    w_phase_next  = w_phase;
    t_hrs_next    = t_hrs;
    t_min_next    = t_min;
    t_sec_next    = t_sec;
    w_hrs_next    = w_hrs;
    w_min_next    = w_min;
    w_sec_next    = w_sec;
    second        = 1'b0;
    prescale_inc  = prescale + 1'b1;

    case (cmd.kind)
      cdt_pkg::CMD_TICK: begin
        if (prescale_inc >= tps) begin
          prescale_next = '0;
          second = 1'b1;
        end else begin
          prescale_next = prescale_inc;
        end
      end
      cdt_pkg::CMD_TIMER_KEY: begin
        unique case (t_phase)
          PH_SETTING: begin
            case (cmd.key)
              cdt_pkg::KEY_DIGIT: begin
                for (int i = 0; i < ND - 1; i++) begin
                  digits_next[i] = digits[i+1];
                end
                digits_next[ND-1] = cmd.digit;
              end
              cdt_pkg::KEY_CLEAR: begin
                for (int i = 0; i < ND; i++) begin
                  digits_next[i] = 4'd0;
                end
              end
              cdt_pkg::KEY_START: begin
                t_hrs_next = ld_hrs;
                t_min_next = ld_min;
                t_sec_next = ld_sec;
                if (entry_nonzero) begin
                  prescale_next = '0;
                  t_phase_next  = PH_RUNNING;
                end
              end
              default: ;
            endcase
          end
          PH_RUNNING, PH_PAUSED: begin
            if (cmd.key == cdt_pkg::KEY_START) begin
              t_phase_next = (t_phase == PH_RUNNING) ? PH_PAUSED : PH_RUNNING;
            end else if (cmd.key == cdt_pkg::KEY_RESET) begin
              t_phase_next = PH_SETTING;
              t_hrs_next = '0;
              t_min_next = '0;
              t_sec_next = '0;
              for (int i = 0; i < ND; i++) begin
                digits_next[i] = 4'd0;
              end
            end
          end
          default: begin
            // Ringing: any real key dismisses the alarm.
            if (cmd.key != cdt_pkg::KEY_NONE) begin
              t_phase_next = PH_SETTING;
              t_hrs_next = '0;
              t_min_next = '0;
              t_sec_next = '0;
              for (int i = 0; i < ND; i++) begin
                digits_next[i] = 4'd0;
              end
            end
          end
        endcase
      end
      cdt_pkg::CMD_WATCH_KEY: begin
        if (cmd.key == cdt_pkg::KEY_START) begin
          w_phase_next = (w_phase == W_ON) ? W_PAUSED : W_ON;
        end else if (cmd.key == cdt_pkg::KEY_RESET) begin
          w_phase_next = W_OFF;
          w_hrs_next = '0;
          w_min_next = '0;
          w_sec_next = '0;
        end
      end
      default: ;
    endcase

    if (second) begin
      if (t_phase == PH_RUNNING) begin
        t_hrs_next = t_hrs_dec;
        t_min_next = t_min_dec;
        t_sec_next = t_sec_dec;
        if (t_hrs_dec == 7'd0 && t_min_dec == 6'd0 && t_sec_dec == 6'd0) begin
          t_phase_next = PH_RINGING;
        end
      end
      // The stopwatch holds at 99:59:59.
      if (w_phase == W_ON && !(w_hrs == 7'd99 && w_min == 6'd59 && w_sec == 6'd59)) begin
        if (w_sec != 6'd59) begin
          w_sec_next = w_sec + 1'b1;
        end else begin
          w_sec_next = '0;
          if (w_min != 6'd59) begin
            w_min_next = w_min + 1'b1;
          end else begin
            w_min_next = '0;
            w_hrs_next = w_hrs + 1'b1;
          end
        end
      end
    end

    if (t_phase_next == PH_SETTING) begin
      disp_h = pair(digits_next[0], digits_next[1]);
      disp_m = pair(digits_next[2], digits_next[3]);
      disp_s = pair(digits_next[4], digits_next[5]);
    end else begin
      disp_h = t_hrs_next;
      disp_m = {1'b0, t_min_next};
      disp_s = {1'b0, t_sec_next};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      out_data <= {3'b000, w_phase_next, w_sec_next, w_min_next, w_hrs_next,
                   (t_phase_next == PH_RINGING), t_phase_next, disp_s, disp_m, disp_h};
    end
    if (rst) begin
      tps       <= cdt_pkg::TPS_RESET;
      prescale  <= '0;
      t_phase   <= PH_SETTING;
      w_phase   <= W_OFF;
      t_hrs     <= '0;
      t_min     <= '0;
      t_sec     <= '0;
      w_hrs     <= '0;
      w_min     <= '0;
      w_sec     <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < ND; i++) begin
        digits[i] <= 4'd0;
      end
    end else begin
      if (cfg_wr_en) begin
        tps <= cfg_wr_data;
      end
      if (cmd_pop) begin
        prescale  <= prescale_next;
        digits    <= digits_next;
        t_phase   <= t_phase_next;
        w_phase   <= w_phase_next;
        t_hrs     <= t_hrs_next;
        t_min     <= t_min_next;
        t_sec     <= t_sec_next;
        w_hrs     <= w_hrs_next;
        w_min     <= w_min_next;
        w_sec     <= w_sec_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### design/countdown_timer_with_stopwatch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Countdown timer and stopwatch
// Keypad-driven countdown timer and up-counting stopwatch sharing one
// seconds prescaler.
// ----------------------------------------------------------------------------
// Every word on the slave stream is either a raw prescaler tick (tuser 0), a
// key for the countdown timer (tuser 1) or a key for the stopwatch (tuser 2);
// tdata carries the ASCII key code. Every accepted word produces exactly one
// word on the master stream with both displays, the two modes and the buzzer.
// The user must write the seconds divider through cfg_wr_en/cfg_wr_data only
// while the block is idle; the block does not enforce this. It resets to 31
// ticks per second. Accepted words are classified and held in a short command
// queue; the execution unit takes one command per cycle while the output is
// not stalled, so words may then arrive on every clock. Each result passes
// through the queue and the output register before it is valid on the master
// stream. When the receiver stalls, the output register holds its word and
// the queue fills; tready falls only when the queue is full, and rises again
// once a command is popped after the output word is taken. Synchronous reset
// clears prescaler, digits, counts and modes and empties queue and output.
// ----------------------------------------------------------------------------
module countdown_timer_with_stopwatch #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] key_code
  input  logic [1:0]  s_axis_tuser,  // [1:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [6:0] timer_hours, [13:7] timer_minutes, [20:14] timer_secs,
  // [22:21] timer_mode, [23] buzzer_on, [30:24] watch_hours,
  // [36:31] watch_minutes, [42:37] watch_secs, [44:43] watch_mode
  output logic [47:0] m_axis_tdata
);

  cdt_pkg::cmd_t in_cmd;
  cdt_pkg::cmd_t head_cmd;
  logic          q_full;
  logic          q_not_empty;
  logic          q_pop;

  assign s_axis_tready = !q_full;

  cdt_front u_front (
    .action   (s_axis_tuser),
    .key_code (s_axis_tdata),
    .cmd      (in_cmd)
  );

  cdt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_axis_tvalid && s_axis_tready),
    .push_cmd  (in_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_cmd  (head_cmd)
  );

  cdt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd_valid   (q_not_empty),
    .cmd         (head_cmd),
    .cmd_pop     (q_pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_data    (m_axis_tdata)
  );

endmodule
